### rtl/lmwd_pkg.sv
package lmwd_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;

    localparam int MODE_W  = 2;
    localparam int LIP_W   = 12;
    localparam int ANG_W   = 13;
    localparam int TIME_W  = 32;
    localparam int WTIME_W = 16;
    localparam int SPRD_W  = ANG_W + 1;
    localparam int THR_W   = 9;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_BIT = 2;

    localparam logic REG_WINDOW_TIME = 1'b0;

    localparam logic [WTIME_W-1:0] WTIME_RESET = 16'd1000;

    // Division by 100 through the reciprocal 2^22/100, rounded up.
    localparam logic [WTIME_W-1:0] RECIP_100   = 16'd41944;
    localparam int                 RECIP_SHIFT = 22;
    localparam int                 QUOT_W      = 10;

    localparam logic [MODE_W-1:0] MODE_FACE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COVERED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOFACE  = 2'd2;

    localparam logic [SPRD_W-1:0] SPRD_5  = 14'd80;
    localparam logic [SPRD_W-1:0] SPRD_8  = 14'd128;
    localparam logic [SPRD_W-1:0] SPRD_10 = 14'd160;
    localparam logic [SPRD_W-1:0] SPRD_15 = 14'd240;
    localparam logic [SPRD_W-1:0] SPRD_20 = 14'd320;
    localparam logic [SPRD_W-1:0] SPRD_30 = 14'd480;

    localparam logic signed [ANG_W-1:0] YAW_37 = 13'sd592;
    localparam logic signed [ANG_W-1:0] YAW_40 = 13'sd640;
    localparam logic signed [ANG_W-1:0] YAW_50 = 13'sd800;

    localparam logic [4:0] THR_10 = 5'd10;
    localparam logic [4:0] THR_12 = 5'd12;
    localparam logic [4:0] THR_15 = 5'd15;
    localparam logic [4:0] THR_18 = 5'd18;
    localparam logic [4:0] THR_20 = 5'd20;
    localparam logic [4:0] THR_25 = 5'd25;
    localparam logic [4:0] THR_30 = 5'd30;

    typedef struct packed {
        logic [LIP_W-1:0]        lip;
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] pitch;
    } entry_t;

    typedef struct packed {
        logic load;
        logic first;
        logic spread_en;
    } scan_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_SPREAD,
        ST_DECIDE,
        ST_OTHER
    } state_t;

    // Later rungs of the ladder override earlier ones; the result is in 1/16 units.
    function automatic logic [THR_W-1:0] pick_thr(logic signed [ANG_W-1:0] max_yaw,
                                                  logic [SPRD_W-1:0] spread);
        logic [4:0] t;
        logic       y37;
        logic       y40;
        logic       y50;
        y37 = max_yaw > YAW_37;
        y40 = max_yaw > YAW_40;
        y50 = max_yaw > YAW_50;
        t = THR_10;
        if (spread > SPRD_5 || (y37 && spread < SPRD_5))
            t = THR_12;
        if (spread > SPRD_10 || (y37 && spread > SPRD_5) || y40)
            t = THR_15;
        if (spread > SPRD_15)
            t = THR_18;
        if (y37 && spread > SPRD_8)
            t = THR_20;
        if (y40 && spread > SPRD_5)
            t = THR_20;
        if (y50 || spread > SPRD_20)
            t = THR_25;
        if (spread > SPRD_30)
            t = THR_30;
        return {t, 4'b0000};
    endfunction

endpackage

### rtl/lmwd_ifs.sv
interface lmwd_in_if;
    logic                                valid;
    logic                                ready;
    logic [lmwd_pkg::MODE_W-1:0]         mode;
    logic [lmwd_pkg::LIP_W-1:0]          lip_open;
    logic signed [lmwd_pkg::ANG_W-1:0]   yaw;
    logic signed [lmwd_pkg::ANG_W-1:0]   pitch;
    logic [lmwd_pkg::TIME_W-1:0]         now_ms;

    modport source (output valid, mode, lip_open, yaw, pitch, now_ms, input ready);
    modport sink (input valid, mode, lip_open, yaw, pitch, now_ms, output ready);
endinterface

interface lmwd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        updated;
    logic                        single_moving;
    logic                        held_moving;
    logic [lmwd_pkg::LIP_W-1:0]  lip_change;

    modport source (output valid, updated, single_moving, held_moving, lip_change,
                    input ready);
    modport sink (input valid, updated, single_moving, held_moving, lip_change,
                  output ready);
endinterface

### rtl/lmwd_cfg.sv
module lmwd_cfg #(
    parameter int DEPTH = lmwd_pkg::WINDOW_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lmwd_pkg::PADDR_W-1:0]   paddr,
    input  logic [lmwd_pkg::PDATA_W-1:0]   pwdata,
    output logic [lmwd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic [lmwd_pkg::WTIME_W-1:0]   window_time,
    output logic [CNT_W-1:0]               win_len
);

    localparam logic [lmwd_pkg::QUOT_W:0] DEPTH_Q = (lmwd_pkg::QUOT_W + 1)'(DEPTH);

    logic [lmwd_pkg::WTIME_W-1:0]   wtime_reg;
    logic [lmwd_pkg::WTIME_W-1:0]   wtime_next;
    logic                           wr_hit;
    logic [2*lmwd_pkg::WTIME_W-1:0] prod;
    logic [lmwd_pkg::QUOT_W-1:0]    quot;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite
                    && (paddr[lmwd_pkg::REG_IDX_BIT] == lmwd_pkg::REG_WINDOW_TIME);
    assign wtime_next = wr_hit ? pwdata[lmwd_pkg::WTIME_W-1:0] : wtime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wtime_reg <= lmwd_pkg::WTIME_RESET;
        end
        else
        begin
            wtime_reg <= wtime_next;
        end
    end

    always_comb
    begin
        if (paddr[lmwd_pkg::REG_IDX_BIT] == lmwd_pkg::REG_WINDOW_TIME)
        begin
            prdata = {{(lmwd_pkg::PDATA_W - lmwd_pkg::WTIME_W){1'b0}}, wtime_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign window_time = wtime_reg;
    assign prod = wtime_reg * lmwd_pkg::RECIP_100;
    assign quot = prod[lmwd_pkg::RECIP_SHIFT +: lmwd_pkg::QUOT_W];

    always_comb
    begin
        if (quot == '0)
        begin
            win_len = CNT_W'(1);
        end
        else if ({1'b0, quot} > DEPTH_Q)
        begin
            win_len = CNT_W'(DEPTH);
        end
        else
        begin
            win_len = CNT_W'(quot);
        end
    end

endmodule

### rtl/lmwd_win_mem.sv
module lmwd_win_mem #(
    parameter int DEPTH = lmwd_pkg::WINDOW_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  lmwd_pkg::entry_t  wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output lmwd_pkg::entry_t  rdata
);

    lmwd_pkg::entry_t mem [DEPTH];
    lmwd_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lmwd_scan.sv
module lmwd_scan (
    input  logic                                clk,
    input  lmwd_pkg::scan_ctl_t                 ctl,
    input  lmwd_pkg::entry_t                    rd_entry,
    output logic [lmwd_pkg::LIP_W-1:0]          max_lip,
    output logic [lmwd_pkg::LIP_W-1:0]          min_lip,
    output logic signed [lmwd_pkg::ANG_W-1:0]   max_yaw,
    output logic [lmwd_pkg::SPRD_W-1:0]         spread
);

    lmwd_pkg::entry_t                    max_reg;
    lmwd_pkg::entry_t                    min_reg;
    logic [lmwd_pkg::SPRD_W-1:0]         spread_reg;
    logic                                take_max;
    logic                                take_min;
    logic signed [lmwd_pkg::SPRD_W-1:0]  dyaw;
    logic signed [lmwd_pkg::SPRD_W-1:0]  dpitch;
    logic [lmwd_pkg::SPRD_W-1:0]         ady;
    logic [lmwd_pkg::SPRD_W-1:0]         adp;
    logic [lmwd_pkg::SPRD_W-1:0]         spread_next;

    // Strict compares keep the oldest entry when openings tie.
    assign take_max = ctl.first || (rd_entry.lip > max_reg.lip);
    assign take_min = ctl.first || (rd_entry.lip < min_reg.lip);

    assign dyaw   = lmwd_pkg::SPRD_W'(max_reg.yaw) - lmwd_pkg::SPRD_W'(min_reg.yaw);
    assign dpitch = lmwd_pkg::SPRD_W'(max_reg.pitch) - lmwd_pkg::SPRD_W'(min_reg.pitch);
    assign ady    = dyaw[lmwd_pkg::SPRD_W-1] ? lmwd_pkg::SPRD_W'(-dyaw) : dyaw;
    assign adp    = dpitch[lmwd_pkg::SPRD_W-1] ? lmwd_pkg::SPRD_W'(-dpitch) : dpitch;
    assign spread_next = (ady > adp) ? ady : adp;

    always_ff @(posedge clk)
    begin
        if (ctl.load && take_max)
        begin
            max_reg <= rd_entry;
        end
        if (ctl.load && take_min)
        begin
            min_reg <= rd_entry;
        end
        if (ctl.spread_en)
        begin
            spread_reg <= spread_next;
        end
    end

    assign max_lip = max_reg.lip;
    assign min_lip = min_reg.lip;
    assign max_yaw = max_reg.yaw;
    assign spread  = spread_reg;

endmodule

### rtl/lip_motion_window_detector.sv
// Lip motion window detector. A request with mode 0 (face seen) is pushed into a
// window of the last window_time_ms/100 frames (at least one, at most WINDOW_DEPTH);
// the window is then scanned one entry per cycle through a memory with separate read
// and write ports to find the widest and narrowest openings, and the head-pose spread
// of those two entries, with the yaw of the widest, selects the movement threshold.
// Such a request passes through the length, write, scan, drain, spread and decide
// states, other modes through a single state, and no request is accepted until the
// block is idle again. A finished result sits in an output register
// while the next request is accepted. Window entries are never read before they
// are written, so the memory needs no clearing after reset. The hold-time register
// lies at byte address 0 of the APB port.
module lip_motion_window_detector #(
    parameter int WINDOW_DEPTH = lmwd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lmwd_in_if.sink                        in_ch,
    lmwd_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lmwd_pkg::PADDR_W-1:0]   paddr,
    input  logic [lmwd_pkg::PDATA_W-1:0]   pwdata,
    output logic [lmwd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW-1:0]  LAST_POS  = AW'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W + 1)'(WINDOW_DEPTH);

    lmwd_pkg::state_t state_reg;
    lmwd_pkg::state_t state_next;

    logic [lmwd_pkg::WTIME_W-1:0] window_time;
    logic [CNT_W-1:0]             win_len;

    logic [CNT_W-1:0]             len_reg;
    logic [CNT_W-1:0]             len_next;
    logic [AW-1:0]                wr_pos_reg;
    logic [AW-1:0]                wr_pos_next;
    logic [CNT_W-1:0]             fill_reg;
    logic [CNT_W-1:0]             fill_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [AW-1:0]                rd_ptr_reg;
    logic [AW-1:0]                rd_ptr_next;
    logic                         dvld_reg;
    logic                         dvld_next;
    logic                         dfirst_reg;
    logic                         dfirst_next;
    logic [lmwd_pkg::TIME_W-1:0]  last_time_reg;
    logic [lmwd_pkg::TIME_W-1:0]  last_time_next;
    logic                         last_single_reg;
    logic                         last_single_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic [lmwd_pkg::MODE_W-1:0]  mode_reg;
    lmwd_pkg::entry_t             item_reg;
    logic [lmwd_pkg::TIME_W-1:0]  now_reg;
    logic                         upd_reg;
    logic                         single_reg;
    logic                         held_reg;
    logic [lmwd_pkg::LIP_W-1:0]   change_reg;
    logic                         upd_next;
    logic                         single_next;
    logic                         held_next;
    logic [lmwd_pkg::LIP_W-1:0]   change_next;

    logic                         accept;
    logic                         slot_free;
    logic                         scan_last;
    logic                         cap_item;
    logic                         load_len;
    logic                         do_write;
    logic                         rd_en;
    logic                         commit_face;
    logic                         commit_other;
    lmwd_pkg::scan_ctl_t          scan_ctl;

    logic [AW-1:0]                wr_inc;
    logic [CNT_W:0]               fill_inc;
    logic [CNT_W-1:0]             fill_new;
    logic [CNT_W:0]               wr_ext;
    logic [CNT_W:0]               fill_ext;
    logic [CNT_W:0]               start_sum;
    logic [AW-1:0]                rd_ptr_inc;

    lmwd_pkg::entry_t             rd_entry;
    logic [lmwd_pkg::LIP_W-1:0]   max_lip;
    logic [lmwd_pkg::LIP_W-1:0]   min_lip;
    logic signed [lmwd_pkg::ANG_W-1:0] max_yaw;
    logic [lmwd_pkg::SPRD_W-1:0]  spread;
    logic [lmwd_pkg::LIP_W-1:0]   change;
    logic [lmwd_pkg::THR_W-1:0]   thr;
    logic                         single;
    logic                         dur_hit;

    lmwd_cfg #(
        .DEPTH (WINDOW_DEPTH),
        .CNT_W (CNT_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .window_time (window_time),
        .win_len     (win_len)
    );

    lmwd_win_mem #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (do_write),
        .waddr (wr_pos_reg),
        .wdata (item_reg),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rd_entry)
    );

    lmwd_scan u_scan (
        .clk      (clk),
        .ctl      (scan_ctl),
        .rd_entry (rd_entry),
        .max_lip  (max_lip),
        .min_lip  (min_lip),
        .max_yaw  (max_yaw),
        .spread   (spread)
    );

    assign in_ch.ready = (state_reg == lmwd_pkg::ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign scan_last   = ({1'b0, cnt_reg} + 1'b1) == {1'b0, fill_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmwd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_ch.mode == lmwd_pkg::MODE_FACE) ? lmwd_pkg::ST_LEN
                                                                     : lmwd_pkg::ST_OTHER;
                end
            end
            lmwd_pkg::ST_LEN:    state_next = lmwd_pkg::ST_WRITE;
            lmwd_pkg::ST_WRITE:  state_next = lmwd_pkg::ST_SCAN;
            lmwd_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = lmwd_pkg::ST_DRAIN;
                end
            end
            lmwd_pkg::ST_DRAIN:  state_next = lmwd_pkg::ST_SPREAD;
            lmwd_pkg::ST_SPREAD: state_next = lmwd_pkg::ST_DECIDE;
            lmwd_pkg::ST_DECIDE, lmwd_pkg::ST_OTHER:
            begin
                if (slot_free)
                begin
                    state_next = lmwd_pkg::ST_IDLE;
                end
            end
            default:             state_next = lmwd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cap_item           = 1'b0;
        load_len           = 1'b0;
        do_write           = 1'b0;
        rd_en              = 1'b0;
        commit_face        = 1'b0;
        commit_other       = 1'b0;
        scan_ctl.spread_en = 1'b0;
        case (state_reg)
            lmwd_pkg::ST_IDLE:   cap_item = accept;
            lmwd_pkg::ST_LEN:    load_len = 1'b1;
            lmwd_pkg::ST_WRITE:  do_write = 1'b1;
            lmwd_pkg::ST_SCAN:   rd_en = 1'b1;
            lmwd_pkg::ST_SPREAD: scan_ctl.spread_en = 1'b1;
            lmwd_pkg::ST_DECIDE: commit_face = slot_free;
            lmwd_pkg::ST_OTHER:  commit_other = slot_free;
            default:
            begin
                cap_item = 1'b0;
            end
        endcase
        scan_ctl.load  = dvld_reg;
        scan_ctl.first = dfirst_reg;
    end

    assign wr_inc     = (wr_pos_reg == LAST_POS) ? '0 : wr_pos_reg + 1'b1;
    assign fill_inc   = {1'b0, fill_reg} + 1'b1;
    assign fill_new   = (fill_inc > {1'b0, len_reg}) ? len_reg : fill_inc[CNT_W-1:0];
    assign wr_ext     = (CNT_W + 1)'(wr_inc);
    assign fill_ext   = {1'b0, fill_new};
    assign start_sum  = (wr_ext >= fill_ext) ? (wr_ext - fill_ext)
                                             : (wr_ext + DEPTH_EXT - fill_ext);
    assign rd_ptr_inc = (rd_ptr_reg == LAST_POS) ? '0 : rd_ptr_reg + 1'b1;

    assign change  = max_lip - min_lip;
    assign thr     = lmwd_pkg::pick_thr(max_yaw, spread);
    assign single  = (fill_reg > CNT_W'(1)) && (change >= lmwd_pkg::LIP_W'(thr));
    assign dur_hit = (now_reg - last_time_reg) >= lmwd_pkg::TIME_W'(window_time);

    always_comb
    begin
        len_next         = load_len ? win_len : len_reg;
        wr_pos_next      = do_write ? wr_inc : wr_pos_reg;
        fill_next        = do_write ? fill_new : fill_reg;
        cnt_next         = do_write ? '0 : (rd_en ? cnt_reg + 1'b1 : cnt_reg);
        rd_ptr_next      = do_write ? AW'(start_sum) : (rd_en ? rd_ptr_inc : rd_ptr_reg);
        dvld_next        = rd_en;
        dfirst_next      = rd_en && (cnt_reg == '0);
        last_time_next   = last_time_reg;
        last_single_next = last_single_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        upd_next         = upd_reg;
        single_next      = single_reg;
        held_next        = held_reg;
        change_next      = change_reg;
        if (commit_face)
        begin
            if (dur_hit || single)
            begin
                last_time_next   = now_reg;
                last_single_next = single;
            end
            out_valid_next = 1'b1;
            upd_next       = 1'b1;
            single_next    = single;
            held_next      = (dur_hit || single) ? single : last_single_reg;
            change_next    = (fill_reg > CNT_W'(1)) ? change : '0;
        end
        if (commit_other)
        begin
            if (dur_hit)
            begin
                last_time_next   = now_reg;
                last_single_next = 1'b0;
            end
            out_valid_next = 1'b1;
            single_next    = 1'b0;
            change_next    = '0;
            if (mode_reg == lmwd_pkg::MODE_COVERED)
            begin
                upd_next  = 1'b0;
                held_next = 1'b0;
            end
            else
            begin
                upd_next  = 1'b1;
                held_next = dur_hit ? 1'b0 : last_single_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lmwd_pkg::ST_IDLE;
            len_reg         <= CNT_W'(1);
            wr_pos_reg      <= '0;
            fill_reg        <= '0;
            cnt_reg         <= '0;
            rd_ptr_reg      <= '0;
            dvld_reg        <= 1'b0;
            dfirst_reg      <= 1'b0;
            last_time_reg   <= '0;
            last_single_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            wr_pos_reg      <= wr_pos_next;
            fill_reg        <= fill_next;
            cnt_reg         <= cnt_next;
            rd_ptr_reg      <= rd_ptr_next;
            dvld_reg        <= dvld_next;
            dfirst_reg      <= dfirst_next;
            last_time_reg   <= last_time_next;
            last_single_reg <= last_single_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_item)
        begin
            mode_reg       <= in_ch.mode;
            item_reg.lip   <= in_ch.lip_open;
            item_reg.yaw   <= in_ch.yaw;
            item_reg.pitch <= in_ch.pitch;
            now_reg        <= in_ch.now_ms;
        end
        upd_reg    <= upd_next;
        single_reg <= single_next;
        held_reg   <= held_next;
        change_reg <= change_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.updated       = upd_reg;
    assign out_ch.single_moving = single_reg;
    assign out_ch.held_moving   = held_reg;
    assign out_ch.lip_change    = change_reg;

endmodule

### test/lip_motion_window_detector_test.sv
module lip_motion_window_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_W = lmwd_pkg::MODE_W;
    localparam int LIP_W = lmwd_pkg::LIP_W;
    localparam int ANG_W = lmwd_pkg::ANG_W;
    localparam int TIME_W = lmwd_pkg::TIME_W;
    localparam int WTIME_W = lmwd_pkg::WTIME_W;
    localparam int PADDR_W = lmwd_pkg::PADDR_W;
    localparam int PDATA_W = lmwd_pkg::PDATA_W;
    localparam int REG_IDX_BIT = lmwd_pkg::REG_IDX_BIT;
    localparam logic REG_WINDOW_TIME = lmwd_pkg::REG_WINDOW_TIME;
    localparam logic [WTIME_W-1:0] WTIME_RESET = lmwd_pkg::WTIME_RESET;
    localparam logic [MODE_W-1:0] MODE_FACE = lmwd_pkg::MODE_FACE;
    localparam logic [MODE_W-1:0] MODE_COVERED = lmwd_pkg::MODE_COVERED;
    localparam logic [MODE_W-1:0] MODE_NOFACE = lmwd_pkg::MODE_NOFACE;

    localparam int DEPTH = lmwd_pkg::WINDOW_DEPTH_DEF;
    localparam int PHASES = 9;
    localparam int PHASE_FRAMES = 150;
    localparam int LONG_HOLD = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 150;
    localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
    localparam logic [PADDR_W-1:0] WINDOW_TIME_ADDR = PADDR_W'(REG_WINDOW_TIME) << REG_IDX_BIT;

    typedef enum int
    {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_style_t;

    typedef struct
    {
        bit               updated;
        bit               single_moving;
        bit               held_moving;
        bit [LIP_W-1:0]   lip_change;
    } lip_status_t;

    class lip_motion_predictor;
        bit [WTIME_W-1:0]        window_time;
        bit [LIP_W-1:0]          lip_mem[DEPTH];
        bit signed [ANG_W-1:0]   yaw_mem[DEPTH];
        bit signed [ANG_W-1:0]   pitch_mem[DEPTH];
        int unsigned             fill;
        int unsigned             wr_pos;
        bit [TIME_W-1:0]         last_change;
        bit                      last_single;
        lip_status_t             expected_status[$];
        int                      failures;

        function void clear();
            window_time = WTIME_RESET;
            fill = 0;
            wr_pos = 0;
            last_change = '0;
            last_single = 1'b0;
            expected_status.delete();
            failures = 0;
        endfunction

        function void set_window_time(input bit [WTIME_W-1:0] value);
            window_time = value;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // The ladder is evaluated from the highest rung down; the first rung that holds wins.
        function int unsigned ladder_threshold(input int max_yaw, input int spread);
            int unsigned rung;
            if (spread > 30 * 16)
                rung = 30;
            else if (max_yaw > 50 * 16 || spread > 20 * 16)
                rung = 25;
            else if ((max_yaw > 37 * 16 && spread > 8 * 16) || (max_yaw > 40 * 16 && spread > 5 * 16))
                rung = 20;
            else if (spread > 15 * 16)
                rung = 18;
            else if (spread > 10 * 16 || (max_yaw > 37 * 16 && spread > 5 * 16) || max_yaw > 40 * 16)
                rung = 15;
            else if (spread > 5 * 16 || (max_yaw > 37 * 16 && spread < 5 * 16))
                rung = 12;
            else
                rung = 10;
            return rung * 16;
        endfunction

        function void note_frame(input logic [MODE_W-1:0] mode, input logic [LIP_W-1:0] lip,
                                 input logic signed [ANG_W-1:0] yaw,
                                 input logic signed [ANG_W-1:0] pitch,
                                 input logic [TIME_W-1:0] now);
            int unsigned span;
            int unsigned first;
            int unsigned slot;
            int unsigned hi;
            int unsigned lo;
            int          yaw_gap;
            int          pitch_gap;
            int          spread;
            int unsigned change;
            int unsigned thr;
            bit          single;
            bit [TIME_W-1:0] elapsed;
            lip_status_t status;
            change = 0;
            single = 1'b0;
            elapsed = now - last_change;
            if (mode != MODE_FACE)
            begin
                if (elapsed >= window_time)
                begin
                    last_change = now;
                    last_single = 1'b0;
                end
                status.updated = (mode != MODE_COVERED);
                status.single_moving = 1'b0;
                status.held_moving = (mode == MODE_COVERED) ? 1'b0 : last_single;
                status.lip_change = '0;
                expected_status.insert(expected_status.size(), status);
                return;
            end
            span = window_time / 100;
            if (span < 1)
                span = 1;
            if (span > DEPTH)
                span = DEPTH;
            lip_mem[wr_pos] = lip;
            yaw_mem[wr_pos] = yaw;
            pitch_mem[wr_pos] = pitch;
            wr_pos = (wr_pos + 1) % DEPTH;
            if (fill < DEPTH)
                fill++;
            if (fill > span)
                fill = span;
            first = (wr_pos + DEPTH - fill) % DEPTH;
            hi = first;
            lo = first;
            for (int i = 1; i < fill; i++)
            begin
                slot = (first + i) % DEPTH;
                if (lip_mem[slot] > lip_mem[hi])
                    hi = slot;
                if (lip_mem[slot] < lip_mem[lo])
                    lo = slot;
            end
            yaw_gap = int'(yaw_mem[hi]) - int'(yaw_mem[lo]);
            pitch_gap = int'(pitch_mem[hi]) - int'(pitch_mem[lo]);
            if (yaw_gap < 0)
                yaw_gap = -yaw_gap;
            if (pitch_gap < 0)
                pitch_gap = -pitch_gap;
            spread = (yaw_gap > pitch_gap) ? yaw_gap : pitch_gap;
            thr = ladder_threshold(int'(yaw_mem[hi]), spread);
            if (fill > 1)
            begin
                change = lip_mem[hi] - lip_mem[lo];
                single = (change >= thr);
            end
            if (elapsed >= window_time || single)
            begin
                last_single = single;
                last_change = now;
            end
            status.updated = 1'b1;
            status.single_moving = single;
            status.held_moving = last_single;
            status.lip_change = change[LIP_W-1:0];
            expected_status.insert(expected_status.size(), status);
        endfunction

        task report(input string what);
            failures++;
            $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task check_status(input logic updated, input logic single_moving, input logic held_moving,
                          input logic [LIP_W-1:0] lip_change);
            lip_status_t want;
            if (expected_status.size() == 0)
            begin
                report("status arrived with no frame outstanding");
                return;
            end
            want = expected_status[0];
            expected_status.delete(0);
            if (updated !== want.updated)
                report($sformatf("updated %b, expected %b", updated, want.updated));
            if (single_moving !== want.single_moving)
                report($sformatf("single_moving %b, expected %b", single_moving,
                                 want.single_moving));
            if (held_moving !== want.held_moving)
                report($sformatf("held_moving %b, expected %b", held_moving, want.held_moving));
            if (lip_change !== want.lip_change)
                report($sformatf("lip_change %0d, expected %0d", lip_change, want.lip_change));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    bit                   hold_request;

    lip_motion_predictor lip_model = new();

    lmwd_in_if  frame_ch();
    lmwd_out_if status_ch();

    lip_motion_window_detector dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (frame_ch),
        .out_ch  (status_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("lip_motion_window_detector_test: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (frame_ch.valid && frame_ch.ready)
            lip_model.note_frame(frame_ch.mode, frame_ch.lip_open, frame_ch.yaw, frame_ch.pitch,
                                 frame_ch.now_ms);
        if (status_ch.valid && status_ch.ready)
            lip_model.check_status(status_ch.updated, status_ch.single_moving,
                                   status_ch.held_moving, status_ch.lip_change);
    end

    initial
    begin : receiver
        ready_style_t style;
        int           left;
        style = READY_ALWAYS;
        left = 0;
        status_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                status_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    style = ready_style_t'($urandom_range(0, 3));
                    left = $urandom_range(50, 400);
                end
                left--;
                case (style)
                    READY_ALWAYS:   status_ch.ready <= 1'b1;
                    READY_COIN:     status_ch.ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:   status_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:        status_ch.ready <= (left % 5 != 0);
                endcase
            end
        end
    end

    task automatic send_frame(input logic [MODE_W-1:0] mode, input logic [LIP_W-1:0] lip,
                              input logic signed [ANG_W-1:0] yaw,
                              input logic signed [ANG_W-1:0] pitch,
                              input logic [TIME_W-1:0] now);
        frame_ch.valid <= 1'b1;
        frame_ch.mode <= mode;
        frame_ch.lip_open <= lip;
        frame_ch.yaw <= yaw;
        frame_ch.pitch <= pitch;
        frame_ch.now_ms <= now;
        do
            @(posedge clk);
        while (!frame_ch.ready);
    endtask

    task automatic wait_drained();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (lip_model.pending() != 0)
            @(posedge clk);
    endtask

    task automatic read_window_time();
        logic [PDATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= WINDOW_TIME_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got[WTIME_W-1:0] !== lip_model.window_time)
            lip_model.report($sformatf("window_time_ms read %0d, expected %0d",
                                       got[WTIME_W-1:0], lip_model.window_time));
    endtask

    task automatic program_window_time(input logic [WTIME_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WINDOW_TIME_ADDR;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        lip_model.set_window_time(value);
        read_window_time();
    endtask

    function automatic int walk_angle(input int cur);
        int roll;
        int next;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return int'($urandom_range(0, 8191)) - 4096;
        if (roll < 15)
            return int'($urandom_range(0, 5760)) - 2880;
        next = cur + int'($urandom_range(0, 192)) - 96;
        if (next > 2880)
            next = 2880;
        if (next < -2880)
            next = -2880;
        return next;
    endfunction

    initial
    begin : stimulus
        int                  lip_walk;
        int                  yaw_walk;
        int                  pitch_walk;
        int                  roll;
        int                  gap;
        int                  burst_left;
        logic [MODE_W-1:0]   mode;
        logic [TIME_W-1:0]   clock_ms;
        logic [WTIME_W-1:0]  window_plan[PHASES];
        int                  pair_yaw[9];
        int                  pair_pitch[9];
        int                  pair_rise[9];
        window_plan = '{16'd0, 16'd100, 16'd250, 16'd1999, 16'd6400, 16'd500, 16'd65535,
                        16'd1000, 16'd0};
        pair_yaw = '{0, 0, 592, 593, 593, 640, 641, 801, 0};
        pair_pitch = '{80, 81, 0, 0, 129, 81, 0, 240, 481};
        pair_rise = '{160, 192, 160, 192, 320, 320, 240, 400, 480};
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        frame_ch.valid <= 1'b0;
        frame_ch.mode <= MODE_FACE;
        frame_ch.lip_open <= '0;
        frame_ch.yaw <= '0;
        frame_ch.pitch <= '0;
        frame_ch.now_ms <= '0;
        lip_model.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_window_time();

        // Single entry, full-scale swing, then covered, no-face and the undefined mode.
        send_frame(MODE_FACE, 12'd0, 13'sd0, 13'sd0, 32'd0);
        send_frame(MODE_FACE, 12'd4095, -13'sd4096, 13'sd4095, 32'd10);
        send_frame(MODE_COVERED, 12'd4095, 13'sd4095, -13'sd4096, 32'd20);
        send_frame(MODE_NOFACE, 12'd2730, 13'sd2730, 13'sd1365, 32'd30);
        send_frame(MODE_UNDEFINED, 12'd1365, 13'sd1365, 13'sd2730, 32'd1030);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Pairs of frames across the threshold ladder, with the clock wrapping through zero.
        program_window_time(16'd200);
        clock_ms = 32'hFFFF_FF00;
        for (int k = 0; k < 9; k++)
        begin
            send_frame(MODE_FACE, 12'd1000, 13'(pair_yaw[k]), 13'sd0, clock_ms);
            clock_ms += 16;
            send_frame(MODE_FACE, 12'(1000 + pair_rise[k]), 13'(pair_yaw[k]),
                       13'(pair_pitch[k]), clock_ms);
            clock_ms += 16;
        end

        lip_walk = 2048;
        yaw_walk = 0;
        pitch_walk = 0;
        burst_left = 0;
        window_plan[PHASES-1] = WTIME_W'($urandom_range(100, 65535));
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            program_window_time(window_plan[p]);
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                if (p == 1 && n == 20)
                    hold_request = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 84)
                    mode = MODE_FACE;
                else if (roll < 91)
                    mode = MODE_COVERED;
                else if (roll < 97)
                    mode = MODE_NOFACE;
                else
                    mode = MODE_UNDEFINED;
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    lip_walk += int'($urandom_range(0, 40)) - 20;
                else if (roll < 75)
                    lip_walk += int'($urandom_range(0, 400)) - 200;
                else if (roll >= 88 && roll < 96)
                    lip_walk = $urandom_range(0, 4095);
                else if (roll >= 96)
                    lip_walk = roll[0] ? 4095 : 0;
                if (lip_walk < 0)
                    lip_walk = 0;
                if (lip_walk > 4095)
                    lip_walk = 4095;
                yaw_walk = walk_angle(yaw_walk);
                pitch_walk = walk_angle(pitch_walk);
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    clock_ms += $urandom_range(20, 50);
                else if (roll < 85)
                    clock_ms += $urandom_range(0, 5);
                else if (roll < 95)
                    clock_ms += $urandom_range(100, 3000);
                else if (roll < 99)
                    clock_ms += $urandom_range(0, 200000);
                else
                    clock_ms = $urandom;
                send_frame(mode, 12'(lip_walk), 13'(yaw_walk), 13'(pitch_walk), clock_ms);
                if (n == PHASE_FRAMES / 2)
                begin
                    wait_drained();
                    burst_left = 0;
                end
                else if (!(p == 1 && n >= 20 && n < 60))
                begin
                    if (burst_left == 0)
                    begin
                        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                        if (gap > 0)
                        begin
                            frame_ch.valid <= 1'b0;
                            repeat (gap) @(posedge clk);
                        end
                        burst_left = $urandom_range(1, 40);
                    end
                    burst_left--;
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (lip_model.failures == 0)
            $display("lip_motion_window_detector_test: PASS");
        else
            $display("lip_motion_window_detector_test: FAIL");
        $finish;
    end

endmodule
